// ----- src/sha256_pkg.sv -----
// Shared types and constants for the SHA-256 message hasher.
package sha256_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned CHAIN_WORDS = 8;
  localparam int unsigned TOTAL_W = 61;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL_LIMIT = 6'd56;

  localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] INIT_H [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       byte_we;
    logic       pad_we;
    logic       len_we;
    logic       load;
    logic       round_en;
    logic       fold;
    logic       restart;
    logic [5:0] rnd;
    logic [2:0] sel;
  } sha256_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_hi;
  } sha256_sts_t;

endpackage

// ----- src/sha256_if.sv -----
// Word channel interfaces for message bytes in and digest words out.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;

  modport source(output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink(input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- src/sha256_ctrl.sv -----
// Sequencing FSM: byte intake, padding, compression rounds and digest readout.
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_byte_valid,
  input  logic                    in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_index,
  output logic                    out_last,
  output sha256_pkg::sha256_cmd_t cmd,
  input  sha256_pkg::sha256_sts_t sts
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROUND = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // what follows the compression in flight
  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [5:0] LAST_RND = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_IDX = 3'(CHAIN_WORDS - 1);

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.rnd   = rnd_r;
    cmd.sel   = idx_r;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_we = in_byte_valid;
          if (in_byte_valid && sts.fill_last) begin
            cmd.load  = 1'b1;
            state_nxt = S_ROUND;
            phase_nxt = in_last ? PH_PAD : PH_DATA;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + 6'd1;
        if (rnd_r == LAST_RND) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        unique case (phase_r)
          PH_DATA: state_nxt = S_IDLE;
          PH_PAD:  state_nxt = S_PAD;
          PH_LEN:  state_nxt = S_LEN;
          PH_DONE: begin
            state_nxt = S_OUT;
            idx_nxt   = 3'd0;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PAD: begin
        cmd.pad_we = 1'b1;
        if (sts.fill_hi) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROUND;
          phase_nxt = PH_LEN;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.len_we = 1'b1;
        cmd.load   = 1'b1;
        state_nxt  = S_ROUND;
        phase_nxt  = PH_DONE;
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_index = idx_r;
  assign out_last  = (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DATA;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == LAST_RND) |=> (state_r == S_FOLD))
    else $error("round count did not end in fold");

  a_digest_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD && phase_r == PH_DONE) |=> (out_valid && idx_r == 3'd0))
    else $error("digest readout not started after length block");

  a_rounds_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ROUND && state_nxt == S_ROUND) |-> (rnd_r == 6'd0))
    else $error("round counter not at zero on block start");
`endif

endmodule

// ----- src/sha256_dp.sv -----
// Datapath: block buffer, message schedule, round logic and chaining value.
module sha256_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              data_byte,
  input  sha256_pkg::sha256_cmd_t cmd,
  output sha256_pkg::sha256_sts_t sts,
  output logic [31:0]             digest_word
);
  import sha256_pkg::*;

  logic [WORD_W-1:0]  blk_r   [BLK_WORDS];
  logic [WORD_W-1:0]  v_r     [CHAIN_WORDS];
  logic [WORD_W-1:0]  chain_r [CHAIN_WORDS];
  logic [TOTAL_W-1:0] total_r;
  logic [5:0]         fill_r;

  logic [WORD_W-1:0] w_new, t1, t2, s0, s1, ch, mj;
  logic [63:0]       bit_len;
  logic [3:0]        wsel;
  logic [4:0]        lane_base;
  logic [7:0]        put_byte;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // schedule window: blk_r[0] is w[r], shifted in is w[r+16]
  assign w_new = (rotr(blk_r[14], 17) ^ rotr(blk_r[14], 19) ^ (blk_r[14] >> 10))
               + blk_r[9]
               + (rotr(blk_r[1], 7) ^ rotr(blk_r[1], 18) ^ (blk_r[1] >> 3))
               + blk_r[0];

  assign s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1 = v_r[7] + s1 + ch + ROUND_K[cmd.rnd] + blk_r[0];
  assign s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2 = s0 + mj;

  assign bit_len   = {total_r, 3'b000};
  assign wsel      = fill_r[5:2];
  assign lane_base = {~fill_r[1:0], 3'b000};
  assign put_byte  = cmd.pad_we ? PAD_BYTE : data_byte;

  assign sts.fill_last = (fill_r == 6'd63);
  assign sts.fill_hi   = (fill_r >= LEN_FILL_LIMIT);
  assign digest_word   = chain_r[cmd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BLK_WORDS; i++) blk_r[i] <= '0;
      for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= INIT_H[i];
      total_r <= '0;
      fill_r  <= '0;
    end else begin
      if (cmd.byte_we || cmd.pad_we) begin
        blk_r[wsel][lane_base +: 8] <= blk_r[wsel][lane_base +: 8] | put_byte;
      end
      if (cmd.byte_we) begin
        fill_r  <= fill_r + 6'd1;
        total_r <= total_r + TOTAL_W'(1);
      end
      if (cmd.len_we) begin
        blk_r[14] <= bit_len[63:32];
        blk_r[15] <= bit_len[31:0];
      end
      if (cmd.round_en) begin
        for (int i = 0; i < BLK_WORDS - 1; i++) blk_r[i] <= blk_r[i+1];
        blk_r[BLK_WORDS-1] <= w_new;
      end
      if (cmd.fold) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= chain_r[i] + v_r[i];
        for (int i = 0; i < BLK_WORDS; i++) blk_r[i] <= '0;
      end
      if (cmd.restart) begin
        for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= INIT_H[i];
        total_r <= '0;
        fill_r  <= '0;
      end
    end
  end

  // working variables a..h
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_WORDS; i++) v_r[i] <= '0;
    end else if (cmd.load) begin
      for (int i = 0; i < CHAIN_WORDS; i++) v_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

// ----- src/sha256_message_hasher_core.sv -----
// SHA-256 message hasher top level: one byte per input word, eight digest words out.
// Message bytes are taken one per cycle while the controller is idle. When a byte
// completes a 64-byte block the input stalls for 64 compression rounds, one per cycle
// in the round datapath, and a fold of the result into the chaining value.
// Finishing a message takes a padding step, a length step and the rounds and fold of
// the final block, plus another such block when 56 or more bytes were pending; the eight
// digest words then go out one per accepted output word, and the next message is
// taken after the eighth.
module sha256_message_hasher_core (
  input  logic         clk,
  input  logic         rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  sha256_cmd_t cmd;
  sha256_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_last       (in_ch.last_byte),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_index     (out_ch.word_index),
    .out_last      (out_ch.last_word),
    .cmd           (cmd),
    .sts           (sts)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_ch.data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (out_ch.digest_word)
  );

endmodule
